// ===== hw/rtl/hmbd_pkg.sv =====
// Package for the HTTP message body deframer: parse phases, constants, queue entry type.
// Used by hmbd_front, hmbd_back and the top level.
package hmbd_pkg;

	localparam int LEN_BITS = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS = 1;

	localparam logic [7:0] CL_LEN = 8'd14;
	localparam logic [7:0] TE_LEN = 8'd17;
	localparam logic [2:0] CH_LEN = 3'd7;

	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_COLON = 8'h3a;

	typedef enum logic [3:0] {
		PH_LINE0   = 4'd0,
		PH_STATUS  = 4'd1,
		PH_LSKIP   = 4'd2,
		PH_HNAME   = 4'd3,
		PH_CLVAL   = 4'd4,
		PH_TEVAL   = 4'd5,
		PH_HSKIP   = 4'd6,
		PH_BODY    = 4'd7,
		PH_CSIZE   = 4'd8,
		PH_CEXT    = 4'd9,
		PH_CDATA   = 4'd10,
		PH_CTAIL   = 4'd11,
		PH_TRAILER = 4'd12
	} phase_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic [9:0] status;
		logic       req;
		logic       last;
	} result_t;

	function automatic logic [7:0] upcase(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7a) ? b - 8'd32 : b;
	endfunction

	function automatic logic [7:0] cl_char(input logic [7:0] i);
		logic [7:0] c;
		case (i)
			8'd0: c = "C";  8'd1: c = "O";  8'd2: c = "N";  8'd3: c = "T";
			8'd4: c = "E";  8'd5: c = "N";  8'd6: c = "T";  8'd7: c = "-";
			8'd8: c = "L";  8'd9: c = "E";  8'd10: c = "N"; 8'd11: c = "G";
			8'd12: c = "T"; 8'd13: c = "H";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] te_char(input logic [7:0] i);
		logic [7:0] c;
		case (i)
			8'd0: c = "T";  8'd1: c = "R";  8'd2: c = "A";  8'd3: c = "N";
			8'd4: c = "S";  8'd5: c = "F";  8'd6: c = "E";  8'd7: c = "R";
			8'd8: c = "-";  8'd9: c = "E";  8'd10: c = "N"; 8'd11: c = "C";
			8'd12: c = "O"; 8'd13: c = "D"; 8'd14: c = "I"; 8'd15: c = "N";
			8'd16: c = "G";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] ch_char(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0: c = "C"; 3'd1: c = "H"; 3'd2: c = "U"; 3'd3: c = "N";
			3'd4: c = "K"; 3'd5: c = "E"; 3'd6: c = "D";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] http_char(input logic [1:0] i);
		logic [7:0] c;
		case (i)
			2'd0: c = "H"; 2'd1: c = "T"; 2'd2: c = "T";
			default: c = "P";
		endcase
		return c;
	endfunction

endpackage

// ===== hw/rtl/hmbd_front.sv =====
// Front end: parses each received byte and classifies it into at most one result.
// Depends on hmbd_pkg.
module hmbd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         rx_byte,
	output logic               res_valid,
	output hmbd_pkg::result_t  res
);
	import hmbd_pkg::*;

	phase_t                ph_q;
	logic [7:0]            pos_q;
	logic [9:0]            stat_q;
	logic                  req_q;
	logic [1:0]            cand_q;
	logic [2:0]            vm_q;
	logic [LEN_BITS-1:0]   blen_q;
	logic                  chunked_q;
	logic [LEN_BITS-1:0]   cleft_q;

	phase_t                ph_d;
	logic [7:0]            pos_d;
	logic [9:0]            stat_d;
	logic                  req_d;
	logic [1:0]            cand_d;
	logic [2:0]            vm_d;
	logic [LEN_BITS-1:0]   blen_d;
	logic                  chunked_d;
	logic [LEN_BITS-1:0]   cleft_d;

	localparam logic [LEN_BITS-1:0] LMAX = '1;
	// saturation thresholds: 10*v+d overflows iff v > (max-d)/10
	localparam logic [LEN_BITS-1:0] DEC_LIM = LMAX / 10;
	localparam logic [3:0] DEC_REM = 4'(LMAX % 10);

	logic [7:0] u;
	logic       is_dig;
	logic [3:0] dig;
	logic       is_hex;
	logic [3:0] hx;
	logic [13:0] stat_next;
	logic [LEN_BITS+3:0] blen_x10;
	logic       clear;
	logic       dec_ovf;

	always_comb begin
		u = upcase(rx_byte);
		is_dig = rx_byte >= "0" && rx_byte <= "9";
		dig = rx_byte[3:0];
		is_hex = is_dig || (u >= "A" && u <= "F");
		hx = is_dig ? rx_byte[3:0] : 4'(u[3:0] + 4'd9);
		stat_next = 14'({stat_q, 3'b000}) + 14'({stat_q, 1'b0}) + 14'(dig);
		blen_x10 = ({4'd0, blen_q} << 3) + ({4'd0, blen_q} << 1) + (LEN_BITS+4)'(dig);
		dec_ovf = (blen_q > DEC_LIM) || (blen_q == DEC_LIM && dig > DEC_REM);

		ph_d = ph_q; pos_d = pos_q; stat_d = stat_q; req_d = req_q;
		cand_d = cand_q; vm_d = vm_q; blen_d = blen_q; chunked_d = chunked_q;
		cleft_d = cleft_q;
		clear = 1'b0;
		res_valid = 1'b0;
		res.kind = 1'b0;
		res.data = rx_byte;
		res.status = stat_q;
		res.req = req_q;
		res.last = 1'b0;

		case (ph_q)
			PH_LINE0: begin
				if (rx_byte == CH_LF) begin
					if (pos_q != 8'd0) begin
						if (pos_q < 8'd4) req_d = 1'b1;
						ph_d = PH_HNAME; pos_d = '0; cand_d = 2'b11; vm_d = '0;
					end
				end else if (rx_byte == CH_CR) begin
				end else if (pos_q < 8'd4) begin
					if (rx_byte != http_char(pos_q[1:0])) begin
						req_d = 1'b1; ph_d = PH_LSKIP;
					end else pos_d = pos_q + 8'd1;
				end else if (rx_byte == CH_SP) ph_d = PH_STATUS;
			end
			PH_STATUS: begin
				if (rx_byte == CH_LF) begin
					ph_d = PH_HNAME; pos_d = '0; cand_d = 2'b11; vm_d = '0;
				end else if (is_dig) begin
					stat_d = (stat_next > 14'd999) ? 10'd999 : stat_next[9:0];
				end else ph_d = PH_LSKIP;
			end
			PH_LSKIP, PH_HSKIP: begin
				if (rx_byte == CH_LF) begin
					ph_d = PH_HNAME; pos_d = '0; cand_d = 2'b11; vm_d = '0;
				end
			end
			PH_HNAME: begin
				if (rx_byte == CH_CR) begin
				end else if (rx_byte == CH_LF) begin
					if (pos_q == 8'd0) begin
						if (chunked_q) begin
							ph_d = PH_CSIZE; cleft_d = '0;
						end else if (blen_q != '0) ph_d = PH_BODY;
						else begin
							res_valid = 1'b1; res.kind = 1'b1; res.data = '0;
							res.last = 1'b1; clear = 1'b1;
						end
					end else begin
						pos_d = '0; cand_d = 2'b11; vm_d = '0;
					end
				end else if (rx_byte == CH_COLON) begin
					if (cand_q[0] && pos_q == CL_LEN) begin
						ph_d = PH_CLVAL; blen_d = '0; pos_d = '0;
					end else if (cand_q[1] && pos_q == TE_LEN) begin
						ph_d = PH_TEVAL; vm_d = '0;
					end else ph_d = PH_HSKIP;
				end else begin
					if (pos_q >= CL_LEN || cl_char(pos_q) != u) cand_d[0] = 1'b0;
					if (pos_q >= TE_LEN || te_char(pos_q) != u) cand_d[1] = 1'b0;
					if (pos_q != 8'd255) pos_d = pos_q + 8'd1;
				end
			end
			PH_CLVAL: begin
				if (rx_byte == CH_LF) begin
					ph_d = PH_HNAME; pos_d = '0; cand_d = 2'b11; vm_d = '0;
				end else if (is_dig) begin
					blen_d = dec_ovf ? LMAX : blen_x10[LEN_BITS-1:0];
					pos_d = 8'd1;
				end else if ((rx_byte == CH_SP || rx_byte == CH_TAB) && pos_q == 8'd0) begin
				end else ph_d = PH_HSKIP;
			end
			PH_TEVAL: begin
				if (rx_byte == CH_LF) begin
					if (vm_q == CH_LEN) chunked_d = 1'b1;
					ph_d = PH_HNAME; pos_d = '0; cand_d = 2'b11; vm_d = '0;
				end else if (rx_byte == CH_CR) begin
				end else if ((rx_byte == CH_SP || rx_byte == CH_TAB) && vm_q == 3'd0) begin
				end else if (vm_q < CH_LEN && u == ch_char(vm_q)) vm_d = vm_q + 3'd1;
				else ph_d = PH_HSKIP;
			end
			PH_BODY: begin
				blen_d = blen_q - 1'b1;
				res_valid = 1'b1;
				if (blen_q == {{(LEN_BITS-1){1'b0}}, 1'b1}) begin
					res.last = 1'b1; clear = 1'b1;
				end
			end
			PH_CSIZE, PH_CEXT: begin
				if (rx_byte == CH_LF) begin
					if (cleft_q == '0) begin
						res_valid = 1'b1; res.kind = 1'b1; res.data = '0; res.last = 1'b1;
						ph_d = PH_TRAILER; pos_d = '0;
					end else ph_d = PH_CDATA;
				end else if (ph_q == PH_CSIZE) begin
					if (is_hex)
						cleft_d = (cleft_q[LEN_BITS-1 -: 4] != 4'd0) ? LMAX
							: {cleft_q[LEN_BITS-5:0], hx};
					else ph_d = PH_CEXT;
				end
			end
			PH_CDATA: begin
				res_valid = 1'b1;
				cleft_d = cleft_q - 1'b1;
				if (cleft_q == {{(LEN_BITS-1){1'b0}}, 1'b1}) ph_d = PH_CTAIL;
			end
			PH_CTAIL: begin
				if (rx_byte == CH_LF) begin
					ph_d = PH_CSIZE; cleft_d = '0;
				end
			end
			PH_TRAILER: begin
				if (rx_byte == CH_CR) begin
				end else if (rx_byte == CH_LF) begin
					if (pos_q == 8'd0) clear = 1'b1;
					else pos_d = '0;
				end else pos_d = 8'd1;
			end
			default: clear = 1'b1;
		endcase

		if (clear) begin
			ph_d = PH_LINE0; pos_d = '0; stat_d = '0; req_d = 1'b0; cand_d = 2'b11;
			vm_d = '0; blen_d = '0; chunked_d = 1'b0; cleft_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_LINE0; pos_q <= '0; stat_q <= '0; req_q <= 1'b0;
			cand_q <= 2'b11; vm_q <= '0; blen_q <= '0; chunked_q <= 1'b0;
			cleft_q <= '0;
		end else if (take) begin
			ph_q <= ph_d; pos_q <= pos_d; stat_q <= stat_d; req_q <= req_d;
			cand_q <= cand_d; vm_q <= vm_d; blen_q <= blen_d; chunked_q <= chunked_d;
			cleft_q <= cleft_d;
		end
	end

	a_stat_range: assert property (@(posedge clk) disable iff (!arst_n) stat_q <= 10'd999)
		else $error("status above 999");
	a_body_len: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_BODY |-> blen_q != '0) else $error("body phase with zero length");
	a_cdata_len: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_CDATA |-> cleft_q != '0) else $error("chunk data with zero left");
	a_req_status: assert property (@(posedge clk) disable iff (!arst_n)
		req_q |-> stat_q == '0) else $error("request with status");
endmodule

// ===== hw/rtl/hmbd_back.sv =====
// Back end: short result queue, read out directly towards the consumer.
// Depends on hmbd_pkg.
module hmbd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  hmbd_pkg::result_t  push_res,
	output logic               full,
	output logic               out_valid,
	input  logic               out_stall,
	output hmbd_pkg::result_t  out_res
);
	import hmbd_pkg::*;

	result_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_q, rd_q;
	logic [QPTR_BITS:0]   cnt_q;
	logic                 pop;

	assign full = cnt_q == (QPTR_BITS+1)'(QUEUE_DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_res = mem_q[rd_q];
	assign pop = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
		end
	end

	a_no_over: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPTR_BITS+1)'(QUEUE_DEPTH)) else $error("queue count out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("stalled result lost");
endmodule

// ===== hw/rtl/http_message_body_deframer.sv =====
// Top level of the HTTP message body deframer.
// Depends on hmbd_pkg, hmbd_front and hmbd_back.
//
// Takes one byte of an HTTP stream per cycle and hands out body bytes and a
// message-complete mark, each tagged with status and request flag. Every byte
// goes through the parser front end; results wait in a two-entry
// queue, so input keeps flowing at one byte per cycle while the consumer takes
// results, and stalls only when the queue is full.
module http_message_body_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       item_kind,
	output logic [7:0] body_byte,
	output logic [9:0] status_code,
	output logic       is_request,
	output logic       message_last
);
	import hmbd_pkg::*;

	logic    take;
	logic    res_valid;
	logic    full;
	result_t res, out_res;

	assign in_stall = full;
	assign take = in_valid && !full;

	hmbd_front u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .rx_byte(rx_byte),
		.res_valid(res_valid), .res(res)
	);

	hmbd_back u_back (
		.clk(clk), .arst_n(arst_n), .push(take && res_valid), .push_res(res),
		.full(full), .out_valid(out_valid), .out_stall(out_stall), .out_res(out_res)
	);

	assign item_kind = out_res.kind;
	assign body_byte = out_res.data;
	assign status_code = out_res.status;
	assign is_request = out_res.req;
	assign message_last = out_res.last;
endmodule

// ===== bench/testbench.sv =====
// Testbench for http_message_body_deframer: byte-stream stimulus, inline parser model, scoreboard.
// Depends on hmbd_pkg and the RTL of the deframer.
`timescale 1ns / 100ps

module testbench;
	import hmbd_pkg::*;

	typedef struct {
		logic       kind;
		logic [7:0] data;
		logic [9:0] status;
		logic       req;
		logic       last;
	} body_item_t;

	class body_scoreboard;
		body_item_t pending[$];
		int unsigned errors;
		phase_t ph;
		logic [7:0] pos;
		logic [9:0] status;
		logic req;
		logic [1:0] cand;
		logic [2:0] vmatch;
		logic [31:0] blen;
		logic chunked;
		logic [31:0] cleft;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			ph = PH_LINE0; pos = 0; status = 0; req = 0; cand = 2'b11;
			vmatch = 0; blen = 0; chunked = 0; cleft = 0;
		endfunction

		function void push(logic kind, logic [7:0] d, logic last);
			body_item_t it;
			it.kind = kind; it.data = d; it.status = status; it.req = req; it.last = last;
			pending.push_back(it);
		endfunction

		function void new_line();
			ph = PH_HNAME; pos = 0; cand = 2'b11; vmatch = 0;
		endfunction

		function void size_done();
			if (cleft == 0) begin
				push(1'b1, 8'h00, 1'b1);
				ph = PH_TRAILER;
				pos = 0;
			end else
				ph = PH_CDATA;
		endfunction

		// Notes one accepted byte and queues whatever result it causes.
		function void note_byte(logic [7:0] b);
			logic [7:0] u, hv;
			logic [13:0] sv;
			logic [31:0] dd;
			u = (b >= "a" && b <= "z") ? b - 8'd32 : b;
			case (ph)
				PH_LINE0: begin
					if (b == CH_LF) begin
						if (pos != 0) begin
							if (pos < 4) req = 1;
							new_line();
						end
					end else if (b == CH_CR) begin
					end else if (pos < 4) begin
						if (b != ("HTTP" >> (8 * (3 - pos))) % 256) begin
							req = 1;
							ph = PH_LSKIP;
						end else
							pos++;
					end else if (b == CH_SP)
						ph = PH_STATUS;
				end
				PH_STATUS: begin
					if (b == CH_LF)
						new_line();
					else if (b >= "0" && b <= "9") begin
						sv = status * 10 + (b - "0");
						status = (sv > 999) ? 10'd999 : sv[9:0];
					end else
						ph = PH_LSKIP;
				end
				PH_LSKIP, PH_HSKIP: if (b == CH_LF) new_line();
				PH_HNAME: begin
					if (b == CH_CR) begin
					end else if (b == CH_LF) begin
						if (pos != 0) new_line();
						else if (chunked) begin
							ph = PH_CSIZE;
							cleft = 0;
						end else if (blen != 0)
							ph = PH_BODY;
						else begin
							push(1'b1, 8'h00, 1'b1);
							clear();
						end
					end else if (b == CH_COLON) begin
						if (cand[0] && pos == CL_LEN) begin
							ph = PH_CLVAL; blen = 0; pos = 0;
						end else if (cand[1] && pos == TE_LEN) begin
							ph = PH_TEVAL; vmatch = 0;
						end else
							ph = PH_HSKIP;
					end else begin
						if (pos >= 14 || u != ("CONTENT-LENGTH" >> (8 * (13 - pos))) % 256)
							cand[0] = 0;
						if (pos >= 17 || u != ("TRANSFER-ENCODING" >> (8 * (16 - pos))) % 256)
							cand[1] = 0;
						if (pos != 255) pos++;
					end
				end
				PH_CLVAL: begin
					if (b == CH_LF)
						new_line();
					else if (b >= "0" && b <= "9") begin
						dd = b - "0";
						blen = (blen > (32'hffffffff - dd) / 10) ? 32'hffffffff : blen * 10 + dd;
						pos = 1;
					end else if (!((b == CH_SP || b == CH_TAB) && pos == 0))
						ph = PH_HSKIP;
				end
				PH_TEVAL: begin
					if (b == CH_LF) begin
						if (vmatch == CH_LEN) chunked = 1;
						new_line();
					end else if (b == CH_CR) begin
					end else if ((b == CH_SP || b == CH_TAB) && vmatch == 0) begin
					end else if (vmatch < CH_LEN && u == ("CHUNKED" >> (8 * (6 - vmatch))) % 256)
						vmatch++;
					else
						ph = PH_HSKIP;
				end
				PH_BODY: begin
					blen = blen - 1;
					if (blen == 0) begin
						push(1'b0, b, 1'b1);
						clear();
					end else
						push(1'b0, b, 1'b0);
				end
				PH_CSIZE: begin
					hv = 8'hff;
					if (b >= "0" && b <= "9") hv = b - "0";
					else if (u >= "A" && u <= "F" && b <= "f" && !(b > "F" && b < "a"))
						hv = u - "A" + 10;
					if (b == CH_LF)
						size_done();
					else if (hv != 8'hff)
						cleft = (cleft > 32'h0fffffff) ? 32'hffffffff : {cleft[27:0], hv[3:0]};
					else
						ph = PH_CEXT;
				end
				PH_CEXT: if (b == CH_LF) size_done();
				PH_CDATA: begin
					push(1'b0, b, 1'b0);
					cleft = cleft - 1;
					if (cleft == 0) ph = PH_CTAIL;
				end
				PH_CTAIL: if (b == CH_LF) begin
					ph = PH_CSIZE;
					cleft = 0;
				end
				PH_TRAILER: begin
					if (b == CH_LF) begin
						if (pos == 0) clear();
						else pos = 0;
					end else if (b != CH_CR)
						pos = 1;
				end
				default: clear();
			endcase
		endfunction

		function void check(logic kind, logic [7:0] d, logic [9:0] st, logic rq, logic last);
			body_item_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result kind=%0d byte=%h status=%0d req=%0d last=%0d",
						kind, d, st, rq, last);
				return;
			end
			e = pending.pop_front();
			if (e.kind !== kind || e.data !== d || e.status !== st || e.req !== rq
					|| e.last !== last) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp k=%0d b=%h s=%0d r=%0d l=%0d got k=%0d b=%h s=%0d r=%0d l=%0d",
						e.kind, e.data, e.status, e.req, e.last, kind, d, st, rq, last);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [7:0] rx_byte;
	logic item_kind, is_request, message_last;
	logic [7:0] body_byte;
	logic [9:0] status_code;

	body_scoreboard sb;
	byte unsigned stream[$];
	int unsigned cycles;
	bit sent_all;

	http_message_body_deframer u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.item_kind(item_kind), .body_byte(body_byte), .status_code(status_code),
		.is_request(is_request), .message_last(message_last)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic byte unsigned flip_case(byte unsigned c);
		if (c >= "A" && c <= "Z" && $urandom_range(0, 1)) return c + 32;
		return c;
	endfunction

	task automatic add_str(string s, bit mix = 1);
		foreach (s[i]) stream.push_back(mix ? flip_case(s[i]) : s[i]);
	endtask

	task automatic add_eol();
		if ($urandom_range(0, 1)) stream.push_back(CH_CR);
		stream.push_back(CH_LF);
	endtask

	task automatic add_random_bytes(int n);
		repeat (n) stream.push_back($urandom_range(0, 255));
	endtask

	// One well-formed message with random content; occasionally damaged.
	task automatic add_message();
		int n, k, sel;
		sel = $urandom_range(0, 9);
		if ($urandom_range(0, 7) == 0) add_eol();
		if (sel < 6) begin
			add_str("HTTP/1.1 ", 0);
			add_str($sformatf("%0d", $urandom_range(0, 1999)), 0);
			add_str(" OK", 0);
		end else
			add_str("POST /x HTTP/1.1", 0);
		add_eol();
		if ($urandom_range(0, 2) == 0) begin
			add_str("Host: a");
			add_eol();
		end
		if ($urandom_range(0, 2) != 0) begin
			add_str("Transfer-Encoding:");
			add_str($urandom_range(0, 1) ? " chunked" : "\tCHUNKE");
			add_eol();
			add_eol();
			k = $urandom_range(0, 3);
			repeat (k) begin
				n = $urandom_range(1, 12);
				add_str($sformatf($urandom_range(0, 1) ? "%0h" : "%0H", n));
				if ($urandom_range(0, 3) == 0) add_str(";ext=1");
				add_eol();
				add_random_bytes(n);
				add_eol();
			end
			add_str("0");
			add_eol();
			if ($urandom_range(0, 2) == 0) begin
				add_str("X-T: 1");
				add_eol();
			end
			add_eol();
		end else begin
			n = $urandom_range(0, 20);
			add_str("Content-Length:");
			add_str($sformatf(" %0d", n));
			add_eol();
			add_eol();
			add_random_bytes(n);
		end
	endtask

	task automatic build_directed();
		add_str("\r\n\nHTTP/1.1 200 OK\r\nContent-Length: 3\r\n\r\nab\xff", 0);
		add_str("HTTP 99999\nCONTENT-LENGTH:\t0\n\n", 0);
		add_str("HT\nx\n\n", 0);
		add_str("GET / HTTP/1.1\ntransfer-encoding: Chunked\n\n", 0);
		add_str("fFfFfFfFfF;e\n", 0);
		stream.push_back(8'h00);
		add_str("\n0\nt\n\n", 0);
		add_str("HTTP/1.0 404\ncontent-length: x\nTransfer-Encoding: gzip\n", 0);
		add_str("Content-Length: 99999999999\nContent-Length: 1\nnocolon\n\n", 0);
		stream.push_back(8'h80);
	endtask

	// Builds the directed and random byte stream, releases reset and feeds the bytes with random gaps.
	initial begin
		int g, done_ok;
		sb = new();
		arst_n = 0;
		in_valid = 0;
		rx_byte = 0;
		out_stall = 0;
		sent_all = 0;
		build_directed();
		repeat (4) add_message();
		while (stream.size() < 1250) begin
			if ($urandom_range(0, 9) == 0) add_random_bytes($urandom_range(1, 10));
			else add_message();
		end
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		while (stream.size() > 0) begin
			g = gap_len();
			if (g > 0) begin
				in_valid <= 0;
				repeat (g) @(posedge clk);
			end
			in_valid <= 1;
			rx_byte <= stream[0];
			@(posedge clk);
			while (in_stall) @(posedge clk);
			sb.note_byte(stream.pop_front());
		end
		in_valid <= 0;
		sent_all = 1;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check(item_kind, body_byte, status_code, is_request, message_last);
	end

	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			g = gap_len();
			if (g > 0) begin
				out_stall <= 1;
				repeat (g) @(posedge clk);
			end
			out_stall <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 200000) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	initial begin
		wait (sent_all);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end
endmodule
